@@ rtl/core/yce_pkg.sv @@
// Shared types, constants and helpers for the YUV to RGB565 color effects unit.
// No dependencies; every other file of the unit uses this package.
`timescale 1ns / 1ps
`default_nettype none

package yce_pkg;

   // Channel accumulator: signed Q13.16 fixed point (30 bits) with headroom for the daltonize sums
   localparam int CW = 30;
   typedef logic signed [CW-1:0] chan_type;

   localparam int CH_BITS    = 24;          // clamp range 0 .. 2^24-1
   localparam int PIXEL_W    = 16;
   localparam int SAMPLE_W   = 8;
   localparam int MODE_W     = 3;
   localparam int THR_W      = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EFFECT_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTIAL_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_THRESHOLD = 2'd2;

   // Effect codes
   localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SIMULATE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INTENSIFY = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FALSE     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DALTONIZE = 3'd4;

   localparam logic [THR_W-1:0] THR_RESET = 18'd2500;

   // Constant multiplier coefficients applied to centered U and V
   localparam int NCOEF = 10;
   typedef logic [19:0] coef_type;

   localparam int KU_92250  = 0;
   localparam int KU_22644  = 1;
   localparam int KU_46990  = 2;
   localparam int KU_116596 = 3;
   localparam int KU_20099  = 4;
   localparam int KU_116690 = 5;
   localparam int KU_140693 = 6;  // 7 * 20099, red difference times seven
   localparam int KU_2545   = 7;  // green difference
   localparam int KU_25189  = 8;  // 2*Ng - Sg
   localparam int KU_116502 = 9;  // 2*Nb - Sb

   localparam int KV_92250  = 0;
   localparam int KV_22644  = 1;
   localparam int KV_46990  = 2;
   localparam int KV_116596 = 3;
   localparam int KV_31341  = 4;
   localparam int KV_558    = 5;
   localparam int KV_123591 = 6;  // red difference
   localparam int KV_865137 = 7;  // 7 * 123591
   localparam int KV_15649  = 8;  // green difference
   localparam int KV_62639  = 9;  // 2*Ng - Sg

   localparam coef_type U_COEF [NCOEF] = '{
      20'd92250, 20'd22644, 20'd46990, 20'd116596, 20'd20099,
      20'd116690, 20'd140693, 20'd2545, 20'd25189, 20'd116502
   };
   localparam coef_type V_COEF [NCOEF] = '{
      20'd92250, 20'd22644, 20'd46990, 20'd116596, 20'd31341,
      20'd558, 20'd123591, 20'd865137, 20'd15649, 20'd62639
   };

   localparam coef_type Y60_COEF = 20'd60000;
   localparam coef_type Y70_COEF = 20'd70000;

   // Truncating divide by 10 of |7*dr| < 2^27: q = (m * ceil(2^31/10)) >> 31
   localparam int MAG_W       = 27;
   localparam int DIV10_SHIFT = 31;
   localparam int DIV10_M_W   = 28;
   localparam logic [DIV10_M_W-1:0] DIV10_M = 28'd214748365;
   localparam int PROD_W      = MAG_W + DIV10_M_W;

   // Partial-mode deltaE
   localparam int RD_W  = 10;
   localparam int GD_W  = 7;
   localparam int SQR_W = 17;
   localparam int SQG_W = 11;
   localparam int DE_W  = 19;

   localparam int PIPE_STAGES = 6;
   localparam int CNT_W       = 3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              partial_en;
      logic [THR_W-1:0]  threshold;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  y;
      chan_type             y60;
      chan_type             y70;
      chan_type [NCOEF-1:0] pu;
      chan_type [NCOEF-1:0] pv;
   } prod_type;

   typedef struct packed {
      chan_type nr, ng, nb;
      chan_type sr, sb;
      chan_type ir, ig;
      chan_type fr, fg, fb;
      chan_type gdal, bdal;
   } chans_type;

   typedef struct packed {
      chans_type ch;
      chan_type  dr;
      chan_type  dr7;
      chan_type  dg;
   } mix_type;

   typedef struct packed {
      chans_type          ch;
      logic [MAG_W-1:0]   mag7;
      logic               neg7;
      logic [SQR_W-1:0]   sq_r;
      logic [SQG_W-1:0]   sq_g;
   } sq_type;

   function automatic logic [CH_BITS-1:0] clamp_ch(input chan_type x);
      logic [CH_BITS-1:0] res;
      if (x[CW-1]) begin
         res = '0;
      end else if (|x[CW-2:CH_BITS]) begin
         res = '1;
      end else begin
         res = x[CH_BITS-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/yce_if.sv @@
// Valid/ready channel interfaces for the pixel input and the RGB565 result.
// Depends on yce_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface yce_req_if;
   logic                         valid;
   logic                         ready;
   logic [yce_pkg::SAMPLE_W-1:0] y_sample;
   logic [yce_pkg::SAMPLE_W-1:0] u_sample;
   logic [yce_pkg::SAMPLE_W-1:0] v_sample;

   modport source (output valid, output y_sample, output u_sample, output v_sample,
                   input ready);
   modport sink   (input valid, input y_sample, input u_sample, input v_sample,
                   output ready);
endinterface

interface yce_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [yce_pkg::PIXEL_W-1:0] pixel_rgb565;

   modport source (output valid, output pixel_rgb565, input ready);
   modport sink   (input valid, input pixel_rgb565, output ready);
endinterface

`default_nettype wire

@@ rtl/core/yce_prod.sv @@
// Stage 1: centers U/V and forms every constant product of the color matrices.
// Depends on yce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yce_prod (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [yce_pkg::SAMPLE_W-1:0] y_sample,
   input  logic [yce_pkg::SAMPLE_W-1:0] u_sample,
   input  logic [yce_pkg::SAMPLE_W-1:0] v_sample,
   output logic                         out_valid,
   input  logic                         out_ready,
   output yce_pkg::prod_type            out_data
);
   import yce_pkg::*;

   logic                       valid_ff;
   prod_type                   data_ff;
   prod_type                   data_in;
   logic signed [SAMPLE_W-1:0] u_c;
   logic signed [SAMPLE_W-1:0] v_c;

   // x - 128 of a byte is the byte with its top bit flipped
   assign u_c = {~u_sample[SAMPLE_W-1], u_sample[SAMPLE_W-2:0]};
   assign v_c = {~v_sample[SAMPLE_W-1], v_sample[SAMPLE_W-2:0]};

   always_comb begin
      data_in.y   = y_sample;
      data_in.y60 = chan_type'(Y60_COEF) * chan_type'(y_sample);
      data_in.y70 = chan_type'(Y70_COEF) * chan_type'(y_sample);
      for (int i = 0; i < NCOEF; i++) begin
         data_in.pu[i] = chan_type'(U_COEF[i]) * chan_type'(u_c);
         data_in.pv[i] = chan_type'(V_COEF[i]) * chan_type'(v_c);
      end
   end

   assign in_ready = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/core/yce_sum.sv @@
// Stages 2 and 3: matrix sums for every effect, then the daltonize magnitude
// and the squared red/green differences for partial mode. Depends on yce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yce_sum (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  yce_pkg::prod_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output yce_pkg::sq_type   out_data
);
   import yce_pkg::*;

   logic                     mix_valid_ff;
   logic                     mix_ready;
   mix_type                  mix_ff;
   mix_type                  mix_in;
   logic                     sq_valid_ff;
   logic                     sq_ready;
   sq_type                   sq_ff;
   sq_type                   sq_in;
   chan_type                 y16;
   chan_type                 neg_dr7;
   logic signed [RD_W-1:0]   rd;
   logic signed [GD_W-1:0]   gd;
   logic signed [2*RD_W-1:0] rsq;
   logic signed [2*GD_W-1:0] gsq;

   // ---- stage 2: matrix sums ----
   assign y16 = chan_type'({in_data.y, 16'b0});

   always_comb begin
      mix_in.ch.nr   = y16 + in_data.pv[KV_92250];
      mix_in.ch.ng   = y16 - in_data.pu[KU_22644] - in_data.pv[KV_46990];
      mix_in.ch.nb   = y16 + in_data.pu[KU_116596];
      mix_in.ch.sr   = y16 - in_data.pu[KU_20099] - in_data.pv[KV_31341];
      mix_in.ch.sb   = y16 + in_data.pu[KU_116690] + in_data.pv[KV_558];
      mix_in.ch.ir   = in_data.y60 + in_data.pv[KV_92250];
      mix_in.ch.ig   = in_data.y70 - in_data.pu[KU_22644] - in_data.pv[KV_46990];
      mix_in.ch.fr   = y16 + in_data.pu[KU_92250];
      mix_in.ch.fg   = y16 - in_data.pv[KV_22644] - in_data.pu[KU_46990];
      mix_in.ch.fb   = y16 + in_data.pv[KV_116596];
      mix_in.ch.gdal = y16 - in_data.pu[KU_25189] - in_data.pv[KV_62639];
      mix_in.ch.bdal = y16 + in_data.pu[KU_116502] - in_data.pv[KV_558];
      mix_in.dr      = in_data.pv[KV_123591] + in_data.pu[KU_20099];
      mix_in.dr7     = in_data.pv[KV_865137] + in_data.pu[KU_140693];
      mix_in.dg      = chan_type'(0) - in_data.pu[KU_2545] - in_data.pv[KV_15649];
   end

   assign mix_ready = ~mix_valid_ff | sq_ready;
   assign in_ready  = mix_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_valid_ff <= 1'b0;
      end else if (mix_ready) begin
         mix_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && mix_ready) begin
         mix_ff <= mix_in;
      end
   end

   // ---- stage 3: magnitude of 7*dr and squared floor(diff / 2^16) ----
   assign neg_dr7 = chan_type'(0) - mix_ff.dr7;
   assign rd      = mix_ff.dr[16+RD_W-1:16];
   assign gd      = mix_ff.dg[16+GD_W-1:16];
   assign rsq     = (2*RD_W)'(rd) * (2*RD_W)'(rd);
   assign gsq     = (2*GD_W)'(gd) * (2*GD_W)'(gd);

   always_comb begin
      sq_in.ch   = mix_ff.ch;
      sq_in.neg7 = mix_ff.dr7[CW-1];
      sq_in.mag7 = mix_ff.dr7[CW-1] ? neg_dr7[MAG_W-1:0] : mix_ff.dr7[MAG_W-1:0];
      sq_in.sq_r = rsq[SQR_W-1:0];
      sq_in.sq_g = gsq[SQG_W-1:0];
   end

   assign sq_ready = ~sq_valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (sq_ready) begin
         sq_valid_ff <= mix_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mix_valid_ff && sq_ready) begin
         sq_ff <= sq_in;
      end
   end

   assign out_valid = sq_valid_ff;
   assign out_data  = sq_ff;

endmodule

`default_nettype wire

@@ rtl/core/yce_pick.sv @@
// Stages 4 to 6: divide by ten, effect decision, channel select, clamp and
// RGB565 packing into the output register. Depends on yce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yce_pick (
   input  logic                        clock,
   input  logic                        reset,
   input  yce_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  yce_pkg::sq_type             in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [yce_pkg::PIXEL_W-1:0] out_pixel
);
   import yce_pkg::*;

   typedef struct packed {
      chans_type         ch;
      logic [MODE_W-1:0] sel;
      logic [PROD_W-1:0] prod;
      logic              neg;
   } dec_type;

   typedef struct packed {
      chan_type r, g, b;
   } rgb_type;

   logic                v4_ff, v5_ff, v6_ff;
   logic                rdy4, rdy5, rdy6;
   dec_type             s4_ff, s4_in;
   rgb_type             s5_ff, s5_in;
   logic [PIXEL_W-1:0]  pix_ff, pix_in;
   logic [DE_W-1:0]     delta_e;
   logic                partial_hit;
   logic [CH_BITS-1:0]  q;
   chan_type            dq;
   chan_type            d;
   logic [CH_BITS-1:0]  rc, gc, bc;

   assign rdy6     = ~v6_ff | out_ready;
   assign rdy5     = ~v5_ff | rdy6;
   assign rdy4     = ~v4_ff | rdy5;
   assign in_ready = rdy4;

   // ---- stage 4: reciprocal multiply and effect decision ----
   assign delta_e = DE_W'({in_data.sq_r, 1'b0}) + DE_W'({in_data.sq_g, 2'b00});
   assign partial_hit = cfg.partial_en && (cfg.mode inside {MODE_INTENSIFY, MODE_FALSE});

   always_comb begin
      s4_in.ch   = in_data.ch;
      s4_in.neg  = in_data.neg7;
      s4_in.prod = PROD_W'(in_data.mag7) * PROD_W'(DIV10_M);
      case (cfg.mode)
         MODE_SIMULATE, MODE_INTENSIFY, MODE_FALSE, MODE_DALTONIZE: begin
            s4_in.sel = cfg.mode;
         end
         default: begin
            s4_in.sel = MODE_NONE;
         end
      endcase
      // partial mode: fall back to plain conversion at or below the threshold
      if (partial_hit && !(delta_e > DE_W'(cfg.threshold))) begin
         s4_in.sel = MODE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && rdy4) begin
         s4_ff <= s4_in;
      end
   end

   // ---- stage 5: daltonize term and channel select ----
   assign q  = s4_ff.prod[PROD_W-1:DIV10_SHIFT];
   assign dq = chan_type'(q);
   assign d  = s4_ff.neg ? chan_type'(0) - dq : dq;

   always_comb begin
      case (s4_ff.sel)
         MODE_SIMULATE: begin
            s5_in.r = s4_ff.ch.sr;
            s5_in.g = s4_ff.ch.sr;
            s5_in.b = s4_ff.ch.sb;
         end
         MODE_INTENSIFY: begin
            s5_in.r = s4_ff.ch.ir;
            s5_in.g = s4_ff.ch.ig;
            s5_in.b = s4_ff.ch.nb;
         end
         MODE_FALSE: begin
            s5_in.r = s4_ff.ch.fr;
            s5_in.g = s4_ff.ch.fg;
            s5_in.b = s4_ff.ch.fb;
         end
         MODE_DALTONIZE: begin
            s5_in.r = s4_ff.ch.nr;
            s5_in.g = s4_ff.ch.gdal + d;
            s5_in.b = s4_ff.ch.bdal + d;
         end
         default: begin
            s5_in.r = s4_ff.ch.nr;
            s5_in.g = s4_ff.ch.ng;
            s5_in.b = s4_ff.ch.nb;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (rdy5) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v4_ff && rdy5) begin
         s5_ff <= s5_in;
      end
   end

   // ---- stage 6: clamp and pack ----
   assign rc     = clamp_ch(s5_ff.r);
   assign gc     = clamp_ch(s5_ff.g);
   assign bc     = clamp_ch(s5_ff.b);
   assign pix_in = {rc[CH_BITS-1:CH_BITS-5], gc[CH_BITS-1:CH_BITS-6], bc[CH_BITS-1:CH_BITS-5]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (rdy6) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v5_ff && rdy6) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_pixel = pix_ff;

endmodule

`default_nettype wire

@@ rtl/core/yuv_to_rgb565_color_effects_unit.sv @@
// YUV to RGB565 color effects unit, top level: configuration registers and the
// six-stage datapath. Depends on yce_pkg, yce_if, yce_prod, yce_sum, yce_pick.
//
// One pixel (Y, U, V bytes) goes in per transfer and one RGB565 word comes out,
// in order. The pipeline accepts a pixel every clock while the output is not
// stalled. Its stages: constant products, matrix sums, difference squares and
// magnitude, a 27x28 reciprocal multiply for the divide by ten of daltonize,
// channel select, then clamp and pack into the output register. Each stage
// holds its own valid bit and stalls only when the stage after it is full, so
// bubbles close up under backpressure. Registers: index 0 effect_mode,
// 1 partial_enable, 2 diff_threshold; write them only while no pixel is in
// flight.
`timescale 1ns / 1ps
`default_nettype none

module yuv_to_rgb565_color_effects_unit (
   input  logic                           clock,
   input  logic                           reset,
   yce_req_if.sink                        req_chan,
   yce_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_en,
   input  logic [yce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [yce_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import yce_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     p_valid, p_ready;
   prod_type p_data;
   logic     s_valid, s_ready;
   sq_type   s_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_EFFECT_MODE:    cfg_in.mode       = csr_wdata[MODE_W-1:0];
            CSR_PARTIAL_ENABLE: cfg_in.partial_en = csr_wdata[0];
            CSR_DIFF_THRESHOLD: cfg_in.threshold  = csr_wdata[THR_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= MODE_NONE;
         cfg_ff.partial_en <= 1'b0;
         cfg_ff.threshold  <= THR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   yce_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .y_sample  (req_chan.y_sample),
      .u_sample  (req_chan.u_sample),
      .v_sample  (req_chan.v_sample),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_data  (p_data)
   );

   yce_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .in_data   (p_data),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_data  (s_data)
   );

   yce_pick u_pick (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_data   (s_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_pixel (rsp_chan.pixel_rgb565)
   );

endmodule

`default_nettype wire

@@ rtl/core/yce_checker.sv @@
// Port-level checks for the YUV to RGB565 color effects unit, bound to the
// top level. Depends on yce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yce_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [yce_pkg::PIXEL_W-1:0] rsp_pixel
);
   import yce_pkg::*;

   logic             req_xfer, rsp_xfer;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // pixels accepted but not yet delivered
   always_comb begin
      cnt_in = cnt_ff;
      if (req_xfer && !rsp_xfer) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (rsp_xfer && !req_xfer) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel))
      else $error("result changed or dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("result presented with no pixel in flight");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == CNT_W'(PIPE_STAGES) && !rsp_xfer |-> !req_ready)
      else $error("input accepted while every stage is occupied");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(PIPE_STAGES))
      else $error("more pixels in flight than pipeline stages");

endmodule

bind yuv_to_rgb565_color_effects_unit yce_checker u_yce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_pixel (rsp_chan.pixel_rgb565)
);

`default_nettype wire
